// ===== rtl/core/plk_pkg.sv =====
// Shared widths, register indexes and breakpoint type for the piecewise-linear lookup.
package plk_pkg;

	// Width of a sample, of a breakpoint coordinate and of a result.
	localparam int VAL_W = 16;

	// Width of the point count register and of the configuration index.
	localparam int CNT_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
	localparam int REG_POINT_BASE = 1;

	// Reset contents of the table.
	localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 3'd2;
	localparam int MIN_POINTS = 2;

	// One breakpoint as packed in its register: x above, y below.
	typedef struct packed {
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
	} point_t;

endpackage

// ===== rtl/core/piecewise_linear_lookup.sv =====
// Piecewise-linear lookup: a sample is clamped or interpolated through a breakpoint table.
// Throughput: one sample per cycle; the whole pipeline advances together and holds
// when the output register is full and not taken.
// The interpolation quotient comes from an eight-stage restoring divider, two bits a stage.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the default table:
// two points, (0, 0) and (0xFFFF, 0xFFFF). Configuration writes are taken every cycle.
module piecewise_linear_lookup #(
	parameter int MAX_POINTS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [plk_pkg::VAL_W-1:0]     sample_in,
	output logic                          value_valid,
	input  logic                          value_ready,
	output logic [plk_pkg::VAL_W-1:0]     value_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [plk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [plk_pkg::CFG_DATA_W-1:0] cfg_data
);
	import plk_pkg::*;

	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = VAL_W / DIV_STEPS;
	localparam int PROD_W = 2 * VAL_W;

	typedef struct packed {
		logic [VAL_W-1:0] rem;
		logic [VAL_W-1:0] quo;
	} div_state_t;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	function automatic div_state_t div_step(div_state_t st, logic [VAL_W-1:0] den);
		logic [VAL_W:0] trial;
		div_state_t nx;
		trial = {st.rem, st.quo[VAL_W-1]};
		if (trial >= {1'b0, den}) begin
			nx.rem = VAL_W'(trial - {1'b0, den});
			nx.quo = {st.quo[VAL_W-2:0], 1'b1};
		end else begin
			nx.rem = trial[VAL_W-1:0];
			nx.quo = {st.quo[VAL_W-2:0], 1'b0};
		end
		return nx;
	endfunction

	// Configuration registers.
	logic [CNT_W-1:0] count_q;
	point_t           points_q [MAX_POINTS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= POINT_COUNT_RESET;
			for (int j = 0; j < MAX_POINTS; j++) begin
				points_q[j] <= (j == 1) ? '1 : '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_POINT_COUNT) begin
				count_q <= cfg_data[CNT_W-1:0];
			end
			for (int j = 0; j < MAX_POINTS; j++) begin
				if (cfg_index == CFG_IDX_W'(REG_POINT_BASE + j)) begin
					points_q[j] <= cfg_data;
				end
			end
		end
	end

	// The pipeline moves as one whenever the output register can take a word.
	logic adv;
	logic valid_s5;

	assign adv          = !valid_s5 || value_ready;
	assign sample_ready = adv;

	// Stage 1: compare the sample against every breakpoint and clamp the count.
	logic                  valid_s1;
	logic [VAL_W-1:0]      s_s1;
	logic [MAX_POINTS-1:0] ge_s1;
	logic [MAX_POINTS-1:0] le_s1;
	logic [CNT_W-1:0]      ncl_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1 <= sample_in;
			for (int j = 0; j < MAX_POINTS; j++) begin
				ge_s1[j] <= sample_in >= points_q[j].x;
				le_s1[j] <= sample_in <= points_q[j].x;
			end
			if (count_q < CNT_W'(MIN_POINTS)) begin
				ncl_s1 <= CNT_W'(MIN_POINTS);
			end else if (count_q > CNT_W'(MAX_POINTS)) begin
				ncl_s1 <= CNT_W'(MAX_POINTS);
			end else begin
				ncl_s1 <= count_q;
			end
		end
	end

	// Stage 2: pick the clamp or the first segment that holds the sample.
	logic             lerp_d;
	logic [VAL_W-1:0] direct_d;
	logic [VAL_W-1:0] x0_d, y0_d, x1_d, y1_d;
	logic             found_d;
	logic             ge_last_d;
	logic [VAL_W-1:0] y_last_d;

	always_comb begin
		ge_last_d = 1'b0;
		y_last_d  = '0;
		for (int j = 0; j < MAX_POINTS; j++) begin
			if (ncl_s1 == CNT_W'(j + 1)) begin
				ge_last_d = ge_s1[j];
				y_last_d  = points_q[j].y;
			end
		end

		found_d = 1'b0;
		lerp_d  = 1'b0;
		direct_d = '0;
		x0_d = '0;
		y0_d = '0;
		x1_d = '0;
		y1_d = '0;
		for (int j = 0; j < MAX_POINTS - 1; j++) begin
			if (!found_d && (CNT_W'(j + 1) < ncl_s1) && ge_s1[j] && le_s1[j + 1]) begin
				found_d = 1'b1;
				x0_d = points_q[j].x;
				y0_d = points_q[j].y;
				x1_d = points_q[j + 1].x;
				y1_d = points_q[j + 1].y;
				if (le_s1[j]) begin
					// The sample sits on the segment's left end.
					direct_d = points_q[j].y;
				end else if (ge_s1[j + 1]) begin
					// The sample sits on the segment's right end.
					direct_d = points_q[j + 1].y;
				end else begin
					lerp_d = 1'b1;
				end
			end
		end

		if (le_s1[0]) begin
			lerp_d   = 1'b0;
			direct_d = points_q[0].y;
		end else if (ge_last_d) begin
			lerp_d   = 1'b0;
			direct_d = y_last_d;
		end else if (!found_d) begin
			lerp_d   = 1'b0;
			direct_d = '0;
		end
	end

	logic             valid_s2;
	logic             lerp_s2;
	logic [VAL_W-1:0] direct_s2;
	logic [VAL_W-1:0] y0_s2;
	logic [VAL_W-1:0] diff_s2;
	logic [VAL_W-1:0] den_s2;
	logic             neg_s2;
	logic [VAL_W-1:0] mag_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			lerp_s2   <= lerp_d;
			direct_s2 <= direct_d;
			y0_s2     <= y0_d;
			diff_s2   <= s_s1 - x0_d;
			den_s2    <= x1_d - x0_d;
			neg_s2    <= y1_d < y0_d;
			mag_s2    <= (y1_d < y0_d) ? (y0_d - y1_d) : (y1_d - y0_d);
		end
	end

	// Stage 3: offset times the magnitude of the rise.
	logic              valid_s3;
	logic              lerp_s3;
	logic [VAL_W-1:0]  direct_s3;
	logic [VAL_W-1:0]  y0_s3;
	logic [VAL_W-1:0]  den_s3;
	logic              neg_s3;
	logic [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			lerp_s3   <= lerp_s2;
			direct_s3 <= direct_s2;
			y0_s3     <= y0_s2;
			den_s3    <= den_s2;
			neg_s3    <= neg_s2;
			prod_s3   <= {{VAL_W{1'b0}}, diff_s2} * {{VAL_W{1'b0}}, mag_s2};
		end
	end

	// Stage 4: restoring divider. The quotient stays below the rise, so it fits VAL_W bits.
	logic             valid_s4  [DIV_STAGES];
	logic             lerp_s4   [DIV_STAGES];
	logic [VAL_W-1:0] direct_s4 [DIV_STAGES];
	logic [VAL_W-1:0] y0_s4     [DIV_STAGES];
	logic [VAL_W-1:0] den_s4    [DIV_STAGES];
	logic             neg_s4    [DIV_STAGES];
	div_state_t       div_s4    [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic             valid_in;
		logic             lerp_in;
		logic [VAL_W-1:0] direct_in;
		logic [VAL_W-1:0] y0_in;
		logic [VAL_W-1:0] den_in;
		logic             neg_in;
		div_state_t       div_in;
		div_state_t       div_out;

		if (k == 0) begin : g_first
			always_comb begin
				valid_in   = valid_s3;
				lerp_in    = lerp_s3;
				direct_in  = direct_s3;
				y0_in      = y0_s3;
				den_in     = den_s3;
				neg_in     = neg_s3;
				div_in.rem = prod_s3[PROD_W-1:VAL_W];
				div_in.quo = prod_s3[VAL_W-1:0];
			end
		end else begin : g_next
			always_comb begin
				valid_in  = valid_s4[k-1];
				lerp_in   = lerp_s4[k-1];
				direct_in = direct_s4[k-1];
				y0_in     = y0_s4[k-1];
				den_in    = den_s4[k-1];
				neg_in    = neg_s4[k-1];
				div_in    = div_s4[k-1];
			end
		end

		// Two quotient bits per stage.
		always_comb begin
			div_out = div_in;
			for (int t = 0; t < DIV_STEPS; t++) begin
				div_out = div_step(div_out, den_in);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s4[k] <= 1'b0;
			end else if (adv) begin
				valid_s4[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lerp_s4[k]   <= lerp_in;
				direct_s4[k] <= direct_in;
				y0_s4[k]     <= y0_in;
				den_s4[k]    <= den_in;
				neg_s4[k]    <= neg_in;
				div_s4[k]    <= div_out;
			end
		end
	end

	// Stage 5: apply the sign of the rise and load the output register.
	logic [VAL_W-1:0] value_s5;
	logic [VAL_W-1:0] quo_last;

	assign quo_last = div_s4[DIV_STAGES-1].quo;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!lerp_s4[DIV_STAGES-1]) begin
				value_s5 <= direct_s4[DIV_STAGES-1];
			end else if (neg_s4[DIV_STAGES-1]) begin
				value_s5 <= y0_s4[DIV_STAGES-1] - quo_last;
			end else begin
				value_s5 <= y0_s4[DIV_STAGES-1] + quo_last;
			end
		end
	end

	// Valid bits of the front stages and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sample_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s5 <= valid_s4[DIV_STAGES-1];
		end
	end

	assign value_valid = valid_s5;
	assign value_out   = value_s5;

endmodule

// ===== rtl/core/plk_checker.sv =====
// Port-level checks for the piecewise-linear lookup, bound to its top level.
module plk_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      sample_ready,
	input logic                      value_valid,
	input logic                      value_ready,
	input logic [plk_pkg::VAL_W-1:0] value_out,
	input logic                      cfg_ready
);
	import plk_pkg::*;

	logic [VAL_W-1:0] value_held;

	assign value_held = value_out;

	// A result word that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && !value_ready |=> value_valid && $stable(value_held))
		else $error("result word changed or dropped while stalled");

	// Samples are taken exactly when the output register can move.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready == (!value_valid || value_ready))
		else $error("sample ready does not follow output backpressure");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port refused a write");

endmodule

bind piecewise_linear_lookup plk_checker u_plk_checker (.*);
